>>> sv/json_string_unescape_utf8_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_TEXT     = 3'd0,
        PH_ESC      = 3'd1,
        PH_HEX      = 3'd2,
        PH_HIGH     = 3'd3,
        PH_HIGH_ESC = 3'd4,
        PH_LOW_HEX  = 3'd5
    } jsu_phase_t;

    localparam int MaxRes = 8;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Result words produced by one input word; cls marks a closing-quote word.
    typedef struct packed {
        logic [MaxRes-1:0][7:0] data;
        logic [MaxRes-1:0]      cls;
        logic [3:0]             cnt;
    } jsu_list_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } jsu_hex_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } jsu_utf8_t;

    function automatic jsu_hex_t hex_digit(input logic [7:0] c);
        jsu_hex_t r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic logic is_high(input logic [15:0] v);
        return v inside {[16'hD800:16'hDBFF]};
    endfunction

    function automatic logic is_low(input logic [15:0] v);
        return v inside {[16'hDC00:16'hDFFF]};
    endfunction

    function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
        jsu_utf8_t r;
        r.b = '0;
        if (cp < 21'h80) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len  = 3'd2;
            r.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.b[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len  = 3'd3;
            r.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            r.b[1] = 8'h80 | {2'b00, cp[11:6]};
            r.b[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            r.b[1] = 8'h80 | {2'b00, cp[17:12]};
            r.b[2] = 8'h80 | {2'b00, cp[11:6]};
            r.b[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

endpackage

>>> sv/json_string_unescape_utf8.sv
// Output: the first result word of an input word appears on m_* the cycle after that word is accepted.
// Throughput: one input word per cycle when each causes at most one result word and
//   m_tready stays high; a word causing several results (up to 8, multi-byte UTF-8
//   and flushes) holds s_tready low until its final result word leaves the buffer,
//   and an m_tready stall holds s_tready low too. Words causing no result leave the buffer empty.
// Reset: synchronous, active-low aresetn; decoder returns to plain text, buffer empties.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] doc_end
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] has_byte, [1] closed
    output logic       m_tlast    // last result word of the input word
);

    // Decoder state advances at input accept; its result list lands in a
    // buffer that drains one word per cycle while m_tready is high.
    jsu_pkg::jsu_list_t list, list_reg;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       s_acc, m_acc, at_last;

    assign m_tvalid = (idx_reg != cnt_reg);
    assign at_last  = ((idx_reg + 4'd1) == cnt_reg);
    assign m_acc    = m_tvalid && m_tready;
    // take a new word when the buffer is empty or its final word leaves now
    assign s_tready = !m_tvalid || (m_tready && at_last);
    assign s_acc    = s_tvalid && s_tready;

    jsu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (s_acc),
        .in_byte (s_tdata),
        .in_end  (s_tuser),
        .list    (list)
    );

    always_comb begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (s_acc) begin
            idx_next = 4'd0;
            cnt_next = list.cnt;
        end else if (m_acc) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            list_reg <= list;
        end
    end

    assign m_tdata    = list_reg.data[idx_reg[2:0]];
    assign m_tuser[0] = !list_reg.cls[idx_reg[2:0]];
    assign m_tuser[1] = list_reg.cls[idx_reg[2:0]];
    assign m_tlast    = at_last;

    `JSU_ASSERT_NOW(a_idx_bound, aclk, aresetn, 1'b1,
        (idx_reg <= cnt_reg) && (cnt_reg <= 4'd8), "result index out of range")
    `JSU_ASSERT_NEXT(a_drain_cont, aclk, aresetn, m_acc && !at_last && !s_acc,
        m_tvalid, "result burst broken before last word")
    `JSU_ASSERT_NOW(a_no_overrun, aclk, aresetn, s_acc && m_tvalid,
        m_acc && m_tlast, "input taken while results pending")
    `JSU_ASSERT_NEXT(a_load, aclk, aresetn, s_acc,
        idx_reg == 4'd0, "result index not restarted on input")

endmodule

>>> sv/jsu_core.sv
// Escape decoder: holds the escape state and turns one input word into
// its list of result words in a single combinational pass.
module jsu_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_acc,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    output jsu_pkg::jsu_list_t list
);

    jsu_pkg::jsu_phase_t phase_reg, phase_next;
    logic [15:0] hv_reg, hv_next;
    logic [2:0]  hc_reg, hc_next;
    logic [15:0] hh_reg, hh_next;
    logic [2:0][7:0] ds_reg;
    logic ds_we;

    logic emit_hi, emit_u, emit_cp, one_en, one_cls;
    logic plain_en, esc_en, single_en;
    logic [7:0]  one_byte;
    logic [20:0] cp;
    logic [15:0] hv4;
    logic [2:0]  hc1;
    jsu_pkg::jsu_hex_t  hd;
    jsu_pkg::jsu_utf8_t uh, uc;

    assign hd  = jsu_pkg::hex_digit(in_byte);
    assign hv4 = {hv_reg[11:0], hd.val};
    assign hc1 = hc_reg + 3'd1;
    assign uh  = jsu_pkg::utf8_enc({5'b00000, hh_reg});
    assign uc  = jsu_pkg::utf8_enc(cp);

    // Phase decode: what to emit and where to go.
    always_comb begin
        phase_next = phase_reg;
        hv_next    = hv_reg;
        hc_next    = hc_reg;
        hh_next    = hh_reg;
        ds_we      = 1'b0;
        emit_hi    = 1'b0;
        emit_u     = 1'b0;
        emit_cp    = 1'b0;
        cp         = '0;
        one_en     = 1'b0;
        one_cls    = 1'b0;
        one_byte   = 8'h00;
        plain_en   = 1'b0;
        esc_en     = 1'b0;
        single_en  = 1'b0;

        if (in_end) begin
            case (phase_reg)
                jsu_pkg::PH_ESC: begin
                    one_en   = 1'b1;
                    one_byte = jsu_pkg::CH_BSLASH;
                end
                jsu_pkg::PH_HEX: begin
                    emit_u = 1'b1;
                end
                jsu_pkg::PH_HIGH: begin
                    emit_hi = 1'b1;
                end
                jsu_pkg::PH_HIGH_ESC: begin
                    emit_hi  = 1'b1;
                    one_en   = 1'b1;
                    one_byte = jsu_pkg::CH_BSLASH;
                end
                jsu_pkg::PH_LOW_HEX: begin
                    emit_hi = 1'b1;
                    emit_u  = 1'b1;
                end
                default: begin
                end
            endcase
            phase_next = jsu_pkg::PH_TEXT;
            hv_next    = '0;
            hc_next    = '0;
            hh_next    = '0;
        end else begin
            case (phase_reg)
                jsu_pkg::PH_ESC: begin
                    esc_en = 1'b1;
                end
                jsu_pkg::PH_HEX: begin
                    if (!hd.ok) begin
                        emit_u   = 1'b1;
                        plain_en = 1'b1;
                    end else begin
                        hv_next   = hv4;
                        hc_next   = hc1;
                        ds_we     = (hc_reg < 3'd3);
                        single_en = (hc1 == 3'd4);
                    end
                end
                jsu_pkg::PH_HIGH: begin
                    if (in_byte == jsu_pkg::CH_BSLASH) begin
                        phase_next = jsu_pkg::PH_HIGH_ESC;
                    end else begin
                        emit_hi  = 1'b1;
                        plain_en = 1'b1;
                    end
                end
                jsu_pkg::PH_HIGH_ESC: begin
                    if (in_byte == jsu_pkg::CH_LOW_U) begin
                        phase_next = jsu_pkg::PH_LOW_HEX;
                        hv_next    = '0;
                        hc_next    = '0;
                    end else begin
                        emit_hi = 1'b1;
                        esc_en  = 1'b1;
                    end
                end
                jsu_pkg::PH_LOW_HEX: begin
                    if (!hd.ok) begin
                        emit_hi  = 1'b1;
                        emit_u   = 1'b1;
                        plain_en = 1'b1;
                    end else begin
                        hv_next = hv4;
                        hc_next = hc1;
                        ds_we   = (hc_reg < 3'd3);
                        if (hc1 == 3'd4) begin
                            if (jsu_pkg::is_low(hv4)) begin
                                // surrogate pair joins into one 4-byte code point
                                emit_cp    = 1'b1;
                                cp         = 21'h10000 + {1'b0, hh_reg[9:0], hv4[9:0]};
                                phase_next = jsu_pkg::PH_TEXT;
                            end else begin
                                emit_hi   = 1'b1;
                                single_en = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    plain_en = 1'b1;
                end
            endcase
        end

        if (plain_en) begin
            phase_next = jsu_pkg::PH_TEXT;
            if (in_byte == jsu_pkg::CH_QUOTE) begin
                one_en  = 1'b1;
                one_cls = 1'b1;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
                phase_next = jsu_pkg::PH_ESC;
            end else begin
                one_en   = 1'b1;
                one_byte = in_byte;
            end
        end

        if (esc_en) begin
            phase_next = jsu_pkg::PH_TEXT;
            one_en     = 1'b1;
            case (in_byte)
                jsu_pkg::CH_LOW_N: one_byte = jsu_pkg::CH_LF;
                jsu_pkg::CH_LOW_R: one_byte = jsu_pkg::CH_CR;
                jsu_pkg::CH_LOW_T: one_byte = jsu_pkg::CH_TAB;
                jsu_pkg::CH_LOW_B: one_byte = jsu_pkg::CH_BS;
                jsu_pkg::CH_LOW_F: one_byte = jsu_pkg::CH_FF;
                jsu_pkg::CH_LOW_U: begin
                    one_en     = 1'b0;
                    phase_next = jsu_pkg::PH_HEX;
                    hv_next    = '0;
                    hc_next    = '0;
                end
                default: one_byte = in_byte;
            endcase
        end

        // four complete digits, not joined: either park a high half or emit
        if (single_en) begin
            if (jsu_pkg::is_high(hv4)) begin
                hh_next    = hv4;
                phase_next = jsu_pkg::PH_HIGH;
            end else begin
                emit_cp    = 1'b1;
                cp         = {5'b00000, hv4};
                phase_next = jsu_pkg::PH_TEXT;
            end
        end
    end

    // List build, fixed order: pending high half, 'u'+digits, code point, single word.
    always_comb begin
        logic [3:0] n;
        n    = 4'd0;
        list = '0;
        if (emit_hi) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < uh.len) begin
                    list.data[n[2:0]] = uh.b[k];
                    n = n + 4'd1;
                end
            end
        end
        if (emit_u) begin
            list.data[n[2:0]] = jsu_pkg::CH_LOW_U;
            n = n + 4'd1;
            for (int k = 0; k < 3; k++) begin
                if (3'(k) < hc_reg) begin
                    list.data[n[2:0]] = ds_reg[k];
                    n = n + 4'd1;
                end
            end
        end
        if (emit_cp) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < uc.len) begin
                    list.data[n[2:0]] = uc.b[k];
                    n = n + 4'd1;
                end
            end
        end
        if (one_en) begin
            list.data[n[2:0]] = one_cls ? 8'h00 : one_byte;
            list.cls[n[2:0]]  = one_cls;
            n = n + 4'd1;
        end
        list.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= jsu_pkg::PH_TEXT;
            hv_reg    <= '0;
            hc_reg    <= '0;
            hh_reg    <= '0;
        end else if (in_acc) begin
            phase_reg <= phase_next;
            hv_reg    <= hv_next;
            hc_reg    <= hc_next;
            hh_reg    <= hh_next;
        end
    end

    // raw digit bytes, only read below hc_reg
    always_ff @(posedge aclk) begin
        if (in_acc && ds_we) begin
            ds_reg[hc_reg[1:0]] <= in_byte;
        end
    end

endmodule
